[rtl/tds_pkg.sv]
`default_nettype none

package tds_pkg;

    localparam int MAX_TAGS  = 16;
    // divisor width: holds 1..MAX_TAGS
    localparam int DIV_W     = $clog2(MAX_TAGS + 1);
    localparam int SUM_W     = 20;
    localparam int DIV_STEPS = SUM_W;
    localparam int BIT_W     = $clog2(DIV_STEPS);
    localparam int AVG_W     = SUM_W + 1;

    localparam logic signed [9:0]  LIN_Q    = 10'sd410;
    localparam logic signed [10:0] TURN_Q   = 11'sd410;
    localparam logic signed [10:0] TURN_LIM = 11'sd819;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_CENTER  = 3'd1,
        PH_STEER   = 3'd2,
        PH_FORWARD = 3'd3,
        PH_DROP    = 3'd4,
        PH_BACKUP  = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        OUT_SUCCESS = 2'd0,
        OUT_BUSY    = 2'd1,
        OUT_FAIL    = 2'd2
    } t_outcome;

    typedef enum logic {
        OP_TICK    = 1'b0,
        OP_RESTART = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        REG_ALLOWED_MISSES = 3'd0,
        REG_IDLE_WAIT_MS   = 3'd1,
        REG_CENTER_MS      = 3'd2,
        REG_STEER_MS       = 3'd3,
        REG_FORWARD_MS     = 3'd4,
        REG_DROP_MS        = 3'd5,
        REG_BACKUP_MS      = 3'd6,
        REG_CENTER_DB      = 3'd7
    } t_reg;

    // microprogram
    typedef logic [1:0] t_step;
    localparam t_step ST_WAIT   = 2'd0;
    localparam t_step ST_PREP   = 2'd1;
    localparam t_step ST_DIV    = 2'd2;
    localparam t_step ST_DECIDE = 2'd3;

    typedef enum logic [1:0] {
        UOP_WAIT,
        UOP_PREP,
        UOP_DIV,
        UOP_DECIDE
    } t_uop;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_IN_VALID,
        C_NO_DIV,
        C_DIV_MORE,
        C_OUT_FREE
    } t_cond;

    typedef struct packed {
        t_uop  op;
        t_cond cond;
        t_step tgt_true;
        t_step tgt_false;
    } t_uword;

    function automatic t_uword uc_rom(input t_step step);
        t_uword w;
        w = '{op: UOP_WAIT, cond: C_ALWAYS, tgt_true: ST_WAIT, tgt_false: ST_WAIT};
        unique case (step)
            ST_WAIT:   w = '{op: UOP_WAIT,   cond: C_IN_VALID,
                             tgt_true: ST_PREP,   tgt_false: ST_WAIT};
            ST_PREP:   w = '{op: UOP_PREP,   cond: C_NO_DIV,
                             tgt_true: ST_DECIDE, tgt_false: ST_DIV};
            ST_DIV:    w = '{op: UOP_DIV,    cond: C_DIV_MORE,
                             tgt_true: ST_DIV,    tgt_false: ST_DECIDE};
            ST_DECIDE: w = '{op: UOP_DECIDE, cond: C_OUT_FREE,
                             tgt_true: ST_WAIT,   tgt_false: ST_DECIDE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[rtl/timed_dropoff_sequencer.sv]
`default_nettype none

// Timed drop-off sequencer. Each input transfer is one control tick (or a
// restart when operation is 1) and yields exactly one result transfer. A tick
// that needs a tag average (center or steer phase with tags in view) goes
// from input transfer to the earliest next input transfer through one prep
// step, a 20-step bit-serial divider, one decide step and the wait step. Other
// ticks and restarts skip the divider. The result sits in an output register, so the
// next tick is taken while it waits; a new result is held back only while
// the previous one has not been transferred. Control comes from a four-word
// microprogram with a step counter. Configuration writes are always ready.
module timed_dropoff_sequencer
    import tds_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,

    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [2:0]              i_cfg_index,
    input  wire logic [15:0]             i_cfg_data,

    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic                    i_operation,
    input  wire logic [31:0]             i_now_ms,
    input  wire logic [4:0]              i_tag_count,
    input  wire logic signed [SUM_W-1:0] i_y_sum,
    input  wire logic signed [SUM_W-1:0] i_theta_sum,

    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [1:0]                   o_outcome,
    output logic [2:0]                   o_phase,
    output logic signed [9:0]            o_linear_speed,
    output logic signed [10:0]           o_turn_rate,
    output logic                         o_fingers_open
);

    // configuration
    logic [7:0]  r_allowed_misses;
    logic [15:0] r_idle_wait_ms, r_center_ms, r_steer_ms;
    logic [15:0] r_forward_ms, r_drop_ms, r_backup_ms;
    logic [11:0] r_center_db;

    // latched tick
    logic                    r_op;
    logic [31:0]             r_now;
    logic [4:0]              r_count;
    logic signed [SUM_W-1:0] r_y, r_theta;

    // sequence state
    t_phase      r_cur, n_cur, r_pend, n_pend;
    logic [31:0] r_start, n_start, r_run, n_run;
    logic [7:0]  r_miss, n_miss;
    logic        r_lost, n_lost;

    // divider
    logic [SUM_W-1:0] r_quo, n_quo;
    logic [DIV_W-1:0] r_rem, n_rem, r_div, n_div;
    logic             r_neg, n_neg;
    logic [BIT_W-1:0] r_bit, n_bit;

    // sequencer
    t_step  r_step, n_step;
    t_uword uw;
    logic   cond_ok;

    // output register
    logic            r_ovalid, n_ovalid;
    t_outcome        r_outcome, n_outcome;
    t_phase          r_ophase, n_ophase;
    logic signed [9:0]  r_lin, n_lin;
    logic signed [10:0] r_turn, n_turn;
    logic            r_fingers, n_fingers;

    logic in_fire, out_free, no_div;
    t_phase ph_upd;
    logic [DIV_W:0] shifted;
    logic [DIV_W:0] trial;
    logic signed [AVG_W-1:0] avg, neg_avg, db_s;
    logic signed [SUM_W-1:0] dvd;

    assign uw          = uc_rom(r_step);
    assign o_in_ready  = (uw.op == UOP_WAIT);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_ovalid || i_out_ready;
    assign o_cfg_ready = 1'b1;

    assign ph_upd = (r_pend != r_cur) ? r_pend : r_cur;
    assign no_div = (r_op == OP_RESTART) || (r_count == '0) ||
                    !((ph_upd == PH_CENTER) || (ph_upd == PH_STEER));
    assign dvd    = (ph_upd == PH_STEER) ? r_theta : r_y;

    assign shifted = {r_rem, r_quo[SUM_W-1]};
    assign trial   = shifted - {1'b0, r_div};

    assign avg     = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign neg_avg = -avg;
    assign db_s    = $signed({{(AVG_W-12){1'b0}}, r_center_db});

    always_comb begin
        case (uw.cond)
            C_ALWAYS:   cond_ok = 1'b1;
            C_IN_VALID: cond_ok = i_in_valid;
            C_NO_DIV:   cond_ok = no_div;
            C_DIV_MORE: cond_ok = (r_bit != BIT_W'(DIV_STEPS - 1));
            C_OUT_FREE: cond_ok = out_free;
            default:    cond_ok = 1'b1;
        endcase
        n_step = cond_ok ? uw.tgt_true : uw.tgt_false;
    end

    always_comb begin
        n_cur     = r_cur;
        n_pend    = r_pend;
        n_start   = r_start;
        n_run     = r_run;
        n_miss    = r_miss;
        n_lost    = r_lost;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_div     = r_div;
        n_neg     = r_neg;
        n_bit     = r_bit;
        n_ovalid  = r_ovalid && !i_out_ready;
        n_outcome = r_outcome;
        n_ophase  = r_ophase;
        n_lin     = r_lin;
        n_turn    = r_turn;
        n_fingers = r_fingers;

        unique case (uw.op)
            UOP_WAIT: ;
            UOP_PREP: begin
                n_rem = '0;
                n_bit = '0;
                n_div = (int'(r_count) > MAX_TAGS) ? DIV_W'(MAX_TAGS) : DIV_W'(r_count);
                n_neg = dvd[SUM_W-1];
                n_quo = no_div ? '0 : (dvd[SUM_W-1] ? SUM_W'(-dvd) : SUM_W'(dvd));
                if (r_op == OP_RESTART) begin
                    n_cur   = PH_IDLE;
                    n_pend  = PH_IDLE;
                    n_start = r_now;
                    n_miss  = '0;
                    n_lost  = 1'b1;
                end else begin
                    n_cur = ph_upd;
                    if (r_pend != r_cur) begin
                        n_start = r_now;
                        n_run   = '0;
                    end else begin
                        n_run = r_now - r_start;
                    end
                    if (r_count != '0) begin
                        n_miss = '0;
                        n_lost = 1'b0;
                    end else begin
                        n_miss = (r_miss == 8'hFF) ? r_miss : r_miss + 8'd1;
                        if (n_miss > r_allowed_misses)
                            n_lost = 1'b1;
                    end
                end
            end
            UOP_DIV: begin
                // restoring division, one quotient bit per cycle
                n_bit = r_bit + BIT_W'(1);
                if (!trial[DIV_W]) begin
                    n_rem = trial[DIV_W-1:0];
                    n_quo = {r_quo[SUM_W-2:0], 1'b1};
                end else begin
                    n_rem = shifted[DIV_W-1:0];
                    n_quo = {r_quo[SUM_W-2:0], 1'b0};
                end
            end
            UOP_DECIDE: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_outcome = OUT_BUSY;
                    n_ophase  = r_cur;
                    n_lin     = '0;
                    n_turn    = '0;
                    n_fingers = 1'b0;
                    if (r_op == OP_RESTART) begin
                        n_outcome = OUT_SUCCESS;
                        n_ophase  = PH_IDLE;
                    end else begin
                        case (r_cur)
                            PH_CENTER: begin
                                if (r_lost) begin
                                    n_pend    = PH_IDLE;
                                    n_outcome = OUT_FAIL;
                                end
                                if (avg > db_s)
                                    n_turn = TURN_Q;
                                else if (avg < -db_s)
                                    n_turn = -TURN_Q;
                                if (r_run > {16'b0, r_center_ms})
                                    n_pend = PH_STEER;
                            end
                            PH_STEER: begin
                                n_lin = LIN_Q;
                                if (neg_avg > AVG_W'(TURN_LIM))
                                    n_turn = TURN_LIM;
                                else if (neg_avg < -AVG_W'(TURN_LIM))
                                    n_turn = -TURN_LIM;
                                else
                                    n_turn = neg_avg[10:0];
                                if ((r_count == '0) || (r_run > {16'b0, r_steer_ms}))
                                    n_pend = PH_FORWARD;
                            end
                            PH_FORWARD: begin
                                n_lin = LIN_Q;
                                if (r_run >= {16'b0, r_forward_ms})
                                    n_pend = PH_DROP;
                            end
                            PH_DROP: begin
                                n_fingers = 1'b1;
                                if (r_run >= {16'b0, r_drop_ms})
                                    n_pend = PH_BACKUP;
                            end
                            PH_BACKUP: begin
                                n_fingers = 1'b1;
                                n_lin     = -LIN_Q;
                                if (r_run >= {16'b0, r_backup_ms}) begin
                                    n_pend    = PH_IDLE;
                                    n_outcome = OUT_SUCCESS;
                                end
                            end
                            default: begin
                                if (r_run > {16'b0, r_idle_wait_ms}) begin
                                    if (r_lost)
                                        n_outcome = OUT_FAIL;
                                    else
                                        n_pend = PH_CENTER;
                                end
                            end
                        endcase
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step           <= ST_WAIT;
            r_cur            <= PH_IDLE;
            r_pend           <= PH_IDLE;
            r_start          <= '0;
            r_miss           <= '0;
            r_lost           <= 1'b1;
            r_ovalid         <= 1'b0;
            r_allowed_misses <= 8'd10;
            r_idle_wait_ms   <= 16'd1000;
            r_center_ms      <= 16'd3000;
            r_steer_ms       <= 16'd3000;
            r_forward_ms     <= 16'd2000;
            r_drop_ms        <= 16'd2000;
            r_backup_ms      <= 16'd3000;
            r_center_db      <= 12'd41;
        end else begin
            r_step   <= n_step;
            r_cur    <= n_cur;
            r_pend   <= n_pend;
            r_start  <= n_start;
            r_miss   <= n_miss;
            r_lost   <= n_lost;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid) begin
                unique case (t_reg'(i_cfg_index))
                    REG_ALLOWED_MISSES: r_allowed_misses <= i_cfg_data[7:0];
                    REG_IDLE_WAIT_MS:   r_idle_wait_ms   <= i_cfg_data;
                    REG_CENTER_MS:      r_center_ms      <= i_cfg_data;
                    REG_STEER_MS:       r_steer_ms       <= i_cfg_data;
                    REG_FORWARD_MS:     r_forward_ms     <= i_cfg_data;
                    REG_DROP_MS:        r_drop_ms        <= i_cfg_data;
                    REG_BACKUP_MS:      r_backup_ms      <= i_cfg_data;
                    REG_CENTER_DB:      r_center_db      <= i_cfg_data[11:0];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op    <= i_operation;
            r_now   <= i_now_ms;
            r_count <= i_tag_count;
            r_y     <= i_y_sum;
            r_theta <= i_theta_sum;
        end
        r_run     <= n_run;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_div     <= n_div;
        r_neg     <= n_neg;
        r_bit     <= n_bit;
        r_outcome <= n_outcome;
        r_ophase  <= n_ophase;
        r_lin     <= n_lin;
        r_turn    <= n_turn;
        r_fingers <= n_fingers;
    end

    assign o_out_valid    = r_ovalid;
    assign o_outcome      = r_outcome;
    assign o_phase        = r_ophase;
    assign o_linear_speed = r_lin;
    assign o_turn_rate    = r_turn;
    assign o_fingers_open = r_fingers;

    a_fire_to_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_step == ST_PREP))
        else $error("input transfer not followed by prep step");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_DIV) |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");

    a_seen_clears_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_step == ST_PREP) && (r_op == OP_TICK) && (r_count != '0))
        |=> (!r_lost && (r_miss == '0)))
        else $error("tags seen but target still lost");

    a_restart_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_step == ST_DECIDE) && out_free && (r_op == OP_RESTART))
        |=> (o_out_valid && (o_outcome == OUT_SUCCESS) && (o_phase == PH_IDLE)
             && (r_cur == PH_IDLE) && (r_pend == PH_IDLE)))
        else $error("restart did not report success in idle");

endmodule

`default_nettype wire

[dv/timed_dropoff_sequencer_test.sv]
`timescale 1ns / 100ps

module timed_dropoff_sequencer_test
    import tds_pkg::*;
();

    typedef struct {
        t_outcome          outcome;
        t_phase            phase;
        logic signed [9:0]  lin;
        logic signed [10:0] turn;
        logic              fingers;
    } t_tick_result;

    // Tracks the sequencer state and queues the command each accepted tick must produce.
    class dropoff_scoreboard;
        logic [7:0]  allowed_misses;
        logic [15:0] idle_wait_ms, center_ms, steer_ms, forward_ms, drop_ms, backup_ms;
        logic [11:0] center_db;

        t_phase      cur_phase, next_phase;
        logic [31:0] phase_t0;
        logic [7:0]  misses;
        logic        lost;

        t_tick_result expected_cmds[$];
        int errors = 0;
        int ticks = 0;
        int restarts = 0;
        int checked = 0;
        int drops_done = 0;
        int fails = 0;
        int phase_hits[6] = '{default: 0};

        function void clear_track(logic [31:0] now);
            cur_phase  = PH_IDLE;
            next_phase = PH_IDLE;
            phase_t0   = now;
            misses     = '0;
            lost       = 1'b1;
        endfunction

        function void power_on();
            allowed_misses = 8'd10;
            idle_wait_ms   = 16'd1000;
            center_ms      = 16'd3000;
            steer_ms       = 16'd3000;
            forward_ms     = 16'd2000;
            drop_ms        = 16'd2000;
            backup_ms      = 16'd3000;
            center_db      = 12'd41;
            clear_track('0);
        endfunction

        function void set_reg(t_reg idx, logic [15:0] d);
            case (idx)
                REG_ALLOWED_MISSES: allowed_misses = d[7:0];
                REG_IDLE_WAIT_MS:   idle_wait_ms   = d;
                REG_CENTER_MS:      center_ms      = d;
                REG_STEER_MS:       steer_ms       = d;
                REG_FORWARD_MS:     forward_ms     = d;
                REG_DROP_MS:        drop_ms        = d;
                REG_BACKUP_MS:      backup_ms      = d;
                REG_CENTER_DB:      center_db      = d[11:0];
            endcase
        endfunction

        function int pending();
            return expected_cmds.size();
        endfunction

        function void note_tick(t_op op, logic [31:0] now, logic [4:0] cnt,
                                logic signed [19:0] y_sum, logic signed [19:0] theta_sum);
            t_tick_result r;
            logic [31:0]  run;
            int n, avg_y, avg_t, db, turn;
            r = '{outcome: OUT_BUSY, phase: PH_IDLE, lin: '0, turn: '0, fingers: 1'b0};
            ticks++;
            if (op == OP_RESTART) begin
                clear_track(now);
                r.outcome = OUT_SUCCESS;
                restarts++;
                expected_cmds.push_back(r);
                return;
            end

            // a phase change decided last tick lands now and restarts the timer
            if (next_phase != cur_phase) begin
                phase_t0  = now;
                cur_phase = next_phase;
            end
            run = now - phase_t0;

            if (cnt != 0) begin
                misses = '0;
                lost   = 1'b0;
            end else begin
                if (misses != 8'hFF)
                    misses++;
                if (misses > allowed_misses)
                    lost = 1'b1;
            end

            avg_y = 0;
            avg_t = 0;
            turn  = 0;
            db    = int'(center_db);
            if (cnt != 0) begin
                n     = (cnt > MAX_TAGS) ? MAX_TAGS : int'(cnt);
                avg_y = int'(y_sum) / n;
                avg_t = int'(theta_sum) / n;
            end

            r.phase = cur_phase;
            phase_hits[cur_phase]++;
            case (cur_phase)
                PH_CENTER: begin
                    if (lost) begin
                        next_phase = PH_IDLE;
                        r.outcome  = OUT_FAIL;
                    end
                    if (avg_y > db)
                        turn = int'(TURN_Q);
                    else if (avg_y < -db)
                        turn = -int'(TURN_Q);
                    if (run > center_ms)
                        next_phase = PH_STEER;
                end
                PH_STEER: begin
                    r.lin = LIN_Q;
                    turn  = -avg_t;
                    if (turn > int'(TURN_LIM))
                        turn = int'(TURN_LIM);
                    if (turn < -int'(TURN_LIM))
                        turn = -int'(TURN_LIM);
                    if (cnt == 0 || run > steer_ms)
                        next_phase = PH_FORWARD;
                end
                PH_FORWARD: begin
                    r.lin = LIN_Q;
                    if (run >= forward_ms)
                        next_phase = PH_DROP;
                end
                PH_DROP: begin
                    r.fingers = 1'b1;
                    if (run >= drop_ms)
                        next_phase = PH_BACKUP;
                end
                PH_BACKUP: begin
                    r.fingers = 1'b1;
                    r.lin     = -LIN_Q;
                    if (run >= backup_ms) begin
                        next_phase = PH_IDLE;
                        r.outcome  = OUT_SUCCESS;
                        drops_done++;
                    end
                end
                default: begin
                    if (run > idle_wait_ms) begin
                        if (lost)
                            r.outcome = OUT_FAIL;
                        else
                            next_phase = PH_CENTER;
                    end
                end
            endcase
            if (r.outcome == OUT_FAIL)
                fails++;
            r.turn = 11'(turn);
            expected_cmds.push_back(r);
        endfunction

        function void check_result(logic [1:0] outcome, logic [2:0] phase,
                                   logic signed [9:0] lin, logic signed [10:0] turn,
                                   logic fingers);
            t_tick_result r;
            if (expected_cmds.size() == 0) begin
                $error("command transfer with no tick outstanding: outcome %0d phase %0d",
                       outcome, phase);
                errors++;
                return;
            end
            r = expected_cmds.pop_front();
            checked++;
            if (outcome !== r.outcome) begin
                $error("outcome: expected %0d, actual %0d", r.outcome, outcome);
                errors++;
            end
            if (phase !== r.phase) begin
                $error("phase: expected %0d, actual %0d", r.phase, phase);
                errors++;
            end
            if (lin !== r.lin) begin
                $error("linear_speed: expected %0d, actual %0d", r.lin, lin);
                errors++;
            end
            if (turn !== r.turn) begin
                $error("turn_rate: expected %0d, actual %0d", r.turn, turn);
                errors++;
            end
            if (fingers !== r.fingers) begin
                $error("fingers_open: expected %0d, actual %0d", r.fingers, fingers);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    wire         cfg_ready;

    logic               in_valid = 1'b0;
    logic               in_op = 1'b0;
    logic [31:0]        in_now = '0;
    logic [4:0]         in_tags = '0;
    logic signed [19:0] in_y = '0;
    logic signed [19:0] in_theta = '0;
    wire                in_ready;

    logic               out_ready = 1'b0;
    wire                out_valid;
    wire [1:0]          outcome_w;
    wire [2:0]          phase_w;
    wire signed [9:0]   lin_w;
    wire signed [10:0]  turn_w;
    wire                fingers_w;

    dropoff_scoreboard sb;
    logic [31:0] now_cursor = '0;
    int in_calm = 0;
    int out_calm = 0;
    int settings = 0;

    timed_dropoff_sequencer uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_operation    (in_op),
        .i_now_ms       (in_now),
        .i_tag_count    (in_tags),
        .i_y_sum        (in_y),
        .i_theta_sum    (in_theta),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_outcome      (outcome_w),
        .o_phase        (phase_w),
        .o_linear_speed (lin_w),
        .o_turn_rate    (turn_w),
        .o_fingers_open (fingers_w)
    );

    always #1 clk = ~clk;

    // idle gap per transfer, with occasional back-to-back stretches
    function automatic int draw_gap(ref int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    function automatic logic [31:0] advance(int step_max);
        if ($urandom_range(0, 199) == 0)
            now_cursor = $urandom();
        else
            now_cursor = now_cursor + $urandom_range(0, step_max);
        return now_cursor;
    endfunction

    // mostly sums that land near the deadband, sometimes full scale
    function automatic logic signed [19:0] pick_sum(logic [4:0] cnt);
        int k;
        k = (cnt == 0) ? 200 : 200 * cnt;
        case ($urandom_range(0, 7))
            0: return 20'sh7FFFF;
            1: return 20'sh80000;
            2: return 20'($urandom());
            default: return 20'($urandom_range(0, 2 * k) - k);
        endcase
    endfunction

    // entered right after a rising edge; returns at the edge of the transfer
    task automatic send_tick(t_op op, logic [31:0] now, logic [4:0] cnt,
                             logic signed [19:0] y_sum, logic signed [19:0] theta_sum);
        int   gap;
        logic took;
        gap = draw_gap(in_calm);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_now   <= now;
        in_tags  <= cnt;
        in_y     <= y_sum;
        in_theta <= theta_sum;
        do begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end while (!took);
        sb.note_tick(op, now, cnt, y_sum, theta_sum);
    endtask

    task automatic write_reg(t_reg idx, logic [15:0] data);
        logic took;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do begin
            @(negedge clk);
            took = cfg_ready;
            @(posedge clk);
        end while (!took);
        sb.set_reg(idx, data);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic load_config(logic [7:0] misses, logic [15:0] idle, logic [15:0] center,
                               logic [15:0] steer, logic [15:0] fwd, logic [15:0] drop,
                               logic [15:0] back, logic [11:0] db);
        settle();
        write_reg(REG_ALLOWED_MISSES, {8'd0, misses});
        write_reg(REG_IDLE_WAIT_MS, idle);
        write_reg(REG_CENTER_MS, center);
        write_reg(REG_STEER_MS, steer);
        write_reg(REG_FORWARD_MS, fwd);
        write_reg(REG_DROP_MS, drop);
        write_reg(REG_BACKUP_MS, back);
        write_reg(REG_CENTER_DB, {4'd0, db});
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic run_phase(int n_items, int step_max, int empty_pct, int burst_max);
        t_op        op;
        logic [4:0] cnt;
        for (int i = 0; i < n_items; i++) begin
            // runs of empty ticks to trip the loss debounce
            if ($urandom_range(0, 59) == 0) begin
                repeat ($urandom_range(1, burst_max))
                    send_tick(OP_TICK, advance(step_max), 5'd0, pick_sum(5'd0), pick_sum(5'd0));
            end
            op = ($urandom_range(0, 99) == 0) ? OP_RESTART : OP_TICK;
            if ($urandom_range(0, 99) < empty_pct)
                cnt = 5'd0;
            else if ($urandom_range(0, 9) == 0)
                cnt = 5'($urandom_range(17, 31));
            else
                cnt = 5'($urandom_range(1, 16));
            send_tick(op, advance(step_max), cnt, pick_sum(cnt), pick_sum(cnt));
        end
    endtask

    // command side: random stalls, check each transfer against the oldest prediction
    initial begin
        int   gap;
        logic took;
        wait (rst_n);
        @(posedge clk);
        forever begin
            gap = draw_gap(out_calm);
            if (gap != 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do begin
                @(negedge clk);
                took = out_valid;
                if (took)
                    sb.check_result(outcome_w, phase_w, lin_w, turn_w, fingers_w);
                @(posedge clk);
            end while (!took);
        end
    end

    initial begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        sb.power_on();

        // one full drop-off on the reset timings, then wrap-around of the ms clock
        send_tick(OP_TICK, 32'd0,     5'd0,  20'sd0,      20'sd0);
        send_tick(OP_TICK, 32'd1001,  5'd0,  20'sd0,      20'sd0);
        send_tick(OP_TICK, 32'd1500,  5'd16, 20'sd16000,  20'sd0);
        send_tick(OP_TICK, 32'd1600,  5'd1,  20'sd500,    20'sd0);
        send_tick(OP_TICK, 32'd1700,  5'd2,  -20'sd1000,  20'sd0);
        send_tick(OP_TICK, 32'd1800,  5'd31, 20'sd656,    20'sd0);
        send_tick(OP_TICK, 32'd1900,  5'd17, -20'sd672,   20'sd0);
        send_tick(OP_TICK, 32'd2000,  5'd3,  20'sh7FFFF,  20'sh80000);
        send_tick(OP_TICK, 32'd4700,  5'd5,  20'sd0,      20'sd0);
        send_tick(OP_TICK, 32'd4800,  5'd1,  20'sd0,      20'sh7FFFF);
        send_tick(OP_TICK, 32'd4900,  5'd1,  20'sd0,      20'sh80000);
        send_tick(OP_TICK, 32'd5000,  5'd4,  20'sd0,      20'sd100);
        send_tick(OP_TICK, 32'd5100,  5'd0,  20'sd0,      20'sd0);
        send_tick(OP_TICK, 32'd5200,  5'd0,  20'sd0,      20'sd0);
        send_tick(OP_TICK, 32'd7200,  5'd8,  20'sd0,      20'sd0);
        send_tick(OP_TICK, 32'd7300,  5'd8,  20'sd0,      20'sd0);
        send_tick(OP_TICK, 32'd9300,  5'd8,  20'sd0,      20'sd0);
        send_tick(OP_TICK, 32'd9301,  5'd8,  20'sd0,      20'sd0);
        send_tick(OP_TICK, 32'd12301, 5'd8,  20'sd0,      20'sd0);
        send_tick(OP_TICK, 32'd12302, 5'd8,  20'sd0,      20'sd0);
        send_tick(OP_RESTART, 32'hFFFF_FF00, 5'h1F, 20'sh7FFFF, 20'sh7FFFF);
        send_tick(OP_TICK, 32'h0000_0100, 5'd0, 20'sd0, 20'sd0);
        send_tick(OP_TICK, 32'hFFFF_FFFF, 5'd0, 20'sd0, 20'sd0);
        now_cursor = 32'hFFFF_FFFF;

        load_config(8'd3, 16'd20, 16'd40, 16'd60, 16'd20, 16'd20, 16'd20, 12'd41);
        run_phase(260, 15, 15, 30);

        // everything at zero: instant timeouts, loss on the first empty tick
        load_config(8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 12'd0);
        run_phase(260, 3, 20, 10);

        load_config(8'($urandom_range(0, 12)), 16'($urandom_range(0, 200)),
                    16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
                    16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
                    16'($urandom_range(0, 200)), 12'($urandom_range(0, 4095)));
        run_phase(260, 60, 15, 30);

        // all maximum; a long empty run saturates the miss counter
        load_config(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    12'hFFF);
        repeat (270)
            send_tick(OP_TICK, advance(40000), 5'd0, pick_sum(5'd0), pick_sum(5'd0));
        run_phase(200, 40000, 10, 20);

        load_config(8'($urandom_range(0, 20)), 16'($urandom_range(0, 3000)),
                    16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
                    16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
                    16'($urandom_range(0, 3000)), 12'($urandom_range(0, 400)));
        run_phase(260, 400, 15, 30);

        load_config(8'd10, 16'd1000, 16'd3000, 16'd3000, 16'd2000, 16'd2000, 16'd3000, 12'd41);
        run_phase(240, 1500, 10, 20);

        settle();
        repeat (40) @(posedge clk);
        $display("%0d ticks (%0d restarts) over %0d register settings, %0d commands checked",
                 sb.ticks, sb.restarts, settings + 1, sb.checked);
        $display("ticks per phase idle/center/steer/fwd/drop/backup %0d/%0d/%0d/%0d/%0d/%0d,",
                 sb.phase_hits[0], sb.phase_hits[1], sb.phase_hits[2], sb.phase_hits[3],
                 sb.phase_hits[4], sb.phase_hits[5]);
        $display("%0d drop-offs, %0d fails", sb.drops_done, sb.fails);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
